// ----- rtl/bsps_pkg.sv -----
// ----------------------------------------------------------------------------
// bsps_pkg
// Shared types, codes and limits for the bistable solenoid pulse sequencer.
// ----------------------------------------------------------------------------
package bsps_pkg;

  localparam int TIME_BITS_DEF = 32;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 32;

  localparam logic [15:0] PULSE_MIN  = 16'd20;
  localparam logic [15:0] PULSE_MAX  = 16'd500;
  localparam logic [15:0] COOL_MIN   = 16'd250;
  localparam logic [15:0] COOL_MAX   = 16'd30000;
  localparam logic [15:0] REPEAT_MAX = 16'd10000;
  localparam int          HALL_TIMEOUT_MS = 1000;

  localparam logic [8:0]  PULSE_LEN_RST = 9'd100;
  localparam logic [14:0] COOL_LEN_RST  = 15'd500;
  localparam logic [14:0] SWITCH_MAX    = 15'h7fff;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_START   = 2'd1,
    OP_ARM     = 2'd2,
    OP_RELEASE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PULSE = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COOL  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_ARMED = 2'd1,
    ST_BUSY      = 2'd2,
    ST_BAD_PARAM = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] now_ms;
    logic        run_allowed;
    logic        hall_a_active;
    logic        hall_b_active;
    logic        start_direction;
    logic [15:0] pulse_length_ms;
    logic [15:0] cooldown_ms;
    logic [15:0] repeat_count;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        drive_enable;
    logic        coil_a;
    logic        coil_b;
    logic        busy_res;
    logic        armed;
    logic [14:0] switch_count;
    logic        failure_count;
    phase_t      phase;
  } result_t;

endpackage

// ----- rtl/bsps_core.sv -----
// ----------------------------------------------------------------------------
// bsps_core
// Sequencer state and the single-pass step logic for one item.
// ----------------------------------------------------------------------------
module bsps_core #(
  parameter int TIME_BITS = bsps_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  bsps_pkg::item_t   item,
  output bsps_pkg::result_t result
);

  logic                  armed_flag, armed_flag_next;
  bsps_pkg::phase_t      run_phase, run_phase_next;
  logic                  pulse_side, pulse_side_next;
  logic [TIME_BITS-1:0]  phase_start_ms, phase_start_ms_next;
  logic [8:0]            pulse_length, pulse_length_next;
  logic [14:0]           cooldown_length, cooldown_length_next;
  logic [14:0]           pulses_left, pulses_left_next;
  logic [14:0]           switch_total, switch_total_next;
  logic                  failure_total, failure_total_next;
  logic                  enable_out, enable_out_next;
  logic                  side_a_out, side_a_out_next;
  logic                  side_b_out, side_b_out_next;
  bsps_pkg::status_t     status;

  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  el;

  assign now_t = item.now_ms[TIME_BITS-1:0];
  assign el    = now_t - phase_start_ms;

  always_comb begin
    logic                 moved;
    logic [TIME_BITS-1:0] el_c;
    logic                 hit;
    logic                 bad;

    armed_flag_next      = armed_flag;
    run_phase_next       = run_phase;
    pulse_side_next      = pulse_side;
    phase_start_ms_next  = phase_start_ms;
    pulse_length_next    = pulse_length;
    cooldown_length_next = cooldown_length;
    pulses_left_next     = pulses_left;
    switch_total_next    = switch_total;
    failure_total_next   = failure_total;
    enable_out_next      = enable_out;
    side_a_out_next      = side_a_out;
    side_b_out_next      = side_b_out;
    status               = bsps_pkg::ST_OK;
    moved                = 1'b0;
    el_c                 = el;
    hit                  = 1'b0;
    bad                  = 1'b0;

    case (item.opcode)
      bsps_pkg::OP_TICK: begin
        if (!item.run_allowed) begin
          enable_out_next = 1'b0;
          side_a_out_next = 1'b0;
          side_b_out_next = 1'b0;
          run_phase_next  = bsps_pkg::PH_IDLE;
          armed_flag_next = 1'b0;
        end else begin
          // end of pulse: drop enable, start the Hall wait
          if (run_phase_next == bsps_pkg::PH_PULSE &&
              el_c >= TIME_BITS'(pulse_length)) begin
            enable_out_next     = 1'b0;
            run_phase_next      = bsps_pkg::PH_WAIT;
            phase_start_ms_next = now_t;
            moved               = 1'b1;
          end
          el_c = moved ? '0 : el;
          if (run_phase_next == bsps_pkg::PH_WAIT) begin
            hit = pulse_side ? item.hall_b_active : item.hall_a_active;
            if (hit) begin
              if (switch_total < bsps_pkg::SWITCH_MAX) begin
                switch_total_next = switch_total + 15'd1;
              end
              run_phase_next      = bsps_pkg::PH_COOL;
              phase_start_ms_next = now_t;
              moved               = 1'b1;
            end else if (el_c >= TIME_BITS'(bsps_pkg::HALL_TIMEOUT_MS)) begin
              failure_total_next = 1'b1;
              enable_out_next    = 1'b0;
              side_a_out_next    = 1'b0;
              side_b_out_next    = 1'b0;
              run_phase_next     = bsps_pkg::PH_IDLE;
            end
          end
          el_c = moved ? '0 : el;
          if (run_phase_next == bsps_pkg::PH_COOL &&
              el_c >= TIME_BITS'(cooldown_length)) begin
            if (pulses_left <= 15'd1) begin
              pulses_left_next = '0;
              enable_out_next  = 1'b0;
              side_a_out_next  = 1'b0;
              side_b_out_next  = 1'b0;
              run_phase_next   = bsps_pkg::PH_IDLE;
            end else begin
              pulses_left_next    = pulses_left - 15'd1;
              pulse_side_next     = ~pulse_side;
              side_a_out_next     = pulse_side;
              side_b_out_next     = ~pulse_side;
              enable_out_next     = 1'b1;
              run_phase_next      = bsps_pkg::PH_PULSE;
              phase_start_ms_next = now_t;
            end
          end
        end
      end
      bsps_pkg::OP_START: begin
        bad = (item.pulse_length_ms < bsps_pkg::PULSE_MIN) ||
              (item.pulse_length_ms > bsps_pkg::PULSE_MAX) ||
              (item.repeat_count    > bsps_pkg::REPEAT_MAX) ||
              (item.cooldown_ms     < bsps_pkg::COOL_MIN) ||
              (item.cooldown_ms     > bsps_pkg::COOL_MAX);
        if (!armed_flag) begin
          status = bsps_pkg::ST_NOT_ARMED;
        end else if (run_phase != bsps_pkg::PH_IDLE) begin
          status = bsps_pkg::ST_BUSY;
        end else if (bad) begin
          status = bsps_pkg::ST_BAD_PARAM;
        end else begin
          pulse_length_next    = item.pulse_length_ms[8:0];
          cooldown_length_next = item.cooldown_ms[14:0];
          // count is at most 10000 here, so doubling fits in 15 bits
          pulses_left_next     = (item.repeat_count == 16'd0) ? 15'd1
                                 : {item.repeat_count[13:0], 1'b0};
          switch_total_next    = '0;
          failure_total_next   = 1'b0;
          pulse_side_next      = item.start_direction;
          side_a_out_next      = ~item.start_direction;
          side_b_out_next      = item.start_direction;
          enable_out_next      = 1'b1;
          run_phase_next       = bsps_pkg::PH_PULSE;
          phase_start_ms_next  = now_t;
        end
      end
      bsps_pkg::OP_ARM: begin
        armed_flag_next = 1'b1;
      end
      default: begin
        enable_out_next = 1'b0;
        side_a_out_next = 1'b0;
        side_b_out_next = 1'b0;
        run_phase_next  = bsps_pkg::PH_IDLE;
        armed_flag_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    result.status        = status;
    result.drive_enable  = enable_out_next;
    result.coil_a        = side_a_out_next;
    result.coil_b        = side_b_out_next;
    result.busy_res      = (run_phase_next != bsps_pkg::PH_IDLE);
    result.armed         = armed_flag_next;
    result.switch_count  = switch_total_next;
    result.failure_count = failure_total_next;
    result.phase         = run_phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed_flag      <= 1'b0;
      run_phase       <= bsps_pkg::PH_IDLE;
      pulse_side      <= 1'b0;
      phase_start_ms  <= '0;
      pulse_length    <= bsps_pkg::PULSE_LEN_RST;
      cooldown_length <= bsps_pkg::COOL_LEN_RST;
      pulses_left     <= '0;
      switch_total    <= '0;
      failure_total   <= 1'b0;
      enable_out      <= 1'b0;
      side_a_out      <= 1'b0;
      side_b_out      <= 1'b0;
    end else if (fire) begin
      armed_flag      <= armed_flag_next;
      run_phase       <= run_phase_next;
      pulse_side      <= pulse_side_next;
      phase_start_ms  <= phase_start_ms_next;
      pulse_length    <= pulse_length_next;
      cooldown_length <= cooldown_length_next;
      pulses_left     <= pulses_left_next;
      switch_total    <= switch_total_next;
      failure_total   <= failure_total_next;
      enable_out      <= enable_out_next;
      side_a_out      <= side_a_out_next;
      side_b_out      <= side_b_out_next;
    end
  end

endmodule

// ----- rtl/bsps_out_buf.sv -----
// ----------------------------------------------------------------------------
// bsps_out_buf
// Two-entry result buffer; ready depends only on its own occupancy.
// ----------------------------------------------------------------------------
module bsps_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bsps_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_ready,
  output bsps_pkg::result_t out_data
);

  bsps_pkg::result_t entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;

  assign pop       = out_valid && out_ready;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/bistable_solenoid_pulse_sequencer.sv -----
// ----------------------------------------------------------------------------
// bistable_solenoid_pulse_sequencer
// Event-driven pulse sequencer for a bistable solenoid with Hall feedback.
// ----------------------------------------------------------------------------
// Each input item is one timestamped event (tick, start, arm, release) and
// produces exactly one result item carrying the status of the event and the
// coil, phase and counter state after it. The block takes one item per clock
// cycle while the output buffer has room: the item is held in an input
// register, the whole step (elapsed-time compares, start checks, phase
// advance, counter updates) is one pass of combinational logic, and the
// result lands in a two-entry output buffer. s_axis_tready stays high
// while a result waits, and drops only once the output buffer holds two
// results and the input register holds a third item. Only the low TIME_BITS
// bits of now_ms are used; elapsed time wraps modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
module bistable_solenoid_pulse_sequencer #(
  parameter int TIME_BITS = bsps_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, low bit up: now_ms[31:0], run_allowed, hall_a_active,
  // hall_b_active, start_direction, pulse_length_ms[15:0], cooldown_ms[15:0],
  // repeat_count[15:0], 4 zero bits
  input  logic [bsps_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: opcode[1:0]
  input  logic [1:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, low bit up: status[1:0], drive_enable, coil_a, coil_b, busy_res,
  // armed, switch_count[14:0], failure_count, phase[1:0], 7 zero bits
  output logic [bsps_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  bsps_pkg::item_t   in_item;
  logic              in_valid;
  logic              buf_full;
  logic              fire;
  bsps_pkg::result_t step_result;
  bsps_pkg::result_t out_result;

  // advance the held item whenever the output buffer has room
  assign fire          = in_valid && !buf_full;
  assign s_axis_tready = !in_valid || !buf_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  // hold payload while stalled
  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item.opcode          <= bsps_pkg::opcode_t'(s_axis_tuser);
      in_item.now_ms          <= s_axis_tdata[31:0];
      in_item.run_allowed     <= s_axis_tdata[32];
      in_item.hall_a_active   <= s_axis_tdata[33];
      in_item.hall_b_active   <= s_axis_tdata[34];
      in_item.start_direction <= s_axis_tdata[35];
      in_item.pulse_length_ms <= s_axis_tdata[51:36];
      in_item.cooldown_ms     <= s_axis_tdata[67:52];
      in_item.repeat_count    <= s_axis_tdata[83:68];
    end
  end

  bsps_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .result (step_result)
  );

  bsps_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (step_result),
    .full      (buf_full),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_result)
  );

  assign m_axis_tdata = {7'd0,
                         out_result.phase,
                         out_result.failure_count,
                         out_result.switch_count,
                         out_result.armed,
                         out_result.busy_res,
                         out_result.coil_b,
                         out_result.coil_a,
                         out_result.drive_enable,
                         out_result.status};

`ifndef ASSERT_OFF
  // never select both coil sides at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[3] && m_axis_tdata[4]))
    else $error("both coil sides selected");

  // the coil is energized only in the pulsing phase
  a_enable_phase: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[2]) |->
      (m_axis_tdata[24:23] == bsps_pkg::PH_PULSE))
    else $error("drive enabled outside pulsing phase");

  // input stalls only with a held item and a full output buffer
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && buf_full))
    else $error("input stalled without backpressure");

  // busy flag agrees with the reported phase
  a_busy_phase: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[5] == (m_axis_tdata[24:23] != bsps_pkg::PH_IDLE)))
    else $error("busy flag disagrees with phase");
`endif

endmodule
